// File: rtl/edid_base_block_generator_assert.svh
// ----------------------------------------------------------------------------
// edid base block generator assertion macros
// shared concurrent checks, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef EDID_BASE_BLOCK_GENERATOR_ASSERT_SVH
`define EDID_BASE_BLOCK_GENERATOR_ASSERT_SVH

// same-cycle implication
`define EBG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ebg_pkg.sv
// ----------------------------------------------------------------------------
// ebg_pkg
// types, constants and the byte map of the generated edid base block
// ----------------------------------------------------------------------------
package ebg_pkg;

  localparam int BLOB_BYTES = 128;
  localparam int OFF_W      = $clog2(BLOB_BYTES);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_W      = 15;
  localparam int DIV_W      = 30;
  localparam int DEN_W      = 16;
  localparam int CNT_W      = $clog2(DIV_W);
  localparam int PROD_A_W   = 29;
  localparam int PROD_B_W   = 37;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_NUM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_DEN  = 3'd3;

  localparam logic [15:0] WIDTH_RESET   = 16'd1920;
  localparam logic [15:0] HEIGHT_RESET  = 16'd1080;
  localparam logic [23:0] REF_NUM_RESET = 24'd60;
  localparam logic [15:0] REF_DEN_RESET = 16'd1;

  localparam logic [15:0] WIDTH_MIN  = 16'd320;
  localparam logic [15:0] HEIGHT_MIN = 16'd240;
  localparam logic [15:0] DIM_MAX    = 16'd16384;
  localparam logic [7:0]  RATE_MIN   = 8'd24;
  localparam logic [7:0]  RATE_MAX   = 8'd240;
  localparam logic [7:0]  RATE_DFLT  = 8'd60;
  localparam logic [DIM_W-1:0] H_BLANK = 15'd80;
  localparam logic [DIM_W-1:0] V_BLANK = 15'd28;

  localparam logic [DEN_W-1:0]    CLK_SCALE   = 16'd10000;
  localparam logic [PROD_B_W-1:0] PROD_MIN    = 37'd10000;
  localparam logic [PROD_B_W-1:0] PROD_LIMIT  = 37'd655360000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_RATE,
    ST_RATE,
    ST_MUL_A,
    ST_MUL_B,
    ST_CHECK,
    ST_DIV_CLK,
    ST_FILL
  } state_t;

  function automatic logic [7:0] blob_byte(input logic [OFF_W-1:0] addr,
                                           input logic [DIM_W-1:0] w,
                                           input logic [DIM_W-1:0] h,
                                           input logic [15:0]      pclk);
    logic [7:0] b;
    b = 8'h00;
    case (addr)
      7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6: b = 8'hff;
      7'd8:   b = 8'h06;
      7'd9:   b = 8'h0f;
      7'd10:  b = 8'h01;
      7'd16:  b = 8'hff;
      7'd17:  b = 8'd35;
      7'd18:  b = 8'h01;
      7'd19:  b = 8'h04;
      7'd20:  b = 8'ha5;
      7'd21:  b = 8'd53;
      7'd22:  b = 8'd30;
      7'd23:  b = 8'd120;
      7'd24:  b = 8'h06;
      7'd25:  b = 8'hee;
      7'd26:  b = 8'h91;
      7'd27:  b = 8'ha3;
      7'd28:  b = 8'h54;
      7'd29:  b = 8'h4c;
      7'd30:  b = 8'h99;
      7'd31:  b = 8'h26;
      7'd32:  b = 8'h0f;
      7'd33:  b = 8'h50;
      7'd34:  b = 8'h54;
      7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45,
      7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53: b = 8'h01;
      7'd54:  b = pclk[7:0];
      7'd55:  b = pclk[15:8];
      7'd56:  b = w[7:0];
      7'd57:  b = 8'd80;
      7'd58:  b = {w[11:8], 4'h0};
      7'd59:  b = h[7:0];
      7'd60:  b = 8'd28;
      7'd61:  b = {h[11:8], 4'h0};
      7'd62:  b = 8'd8;
      7'd63:  b = 8'd32;
      7'd64:  b = 8'h35;
      7'd71:  b = 8'h1e;
      7'd75:  b = 8'hfc;
      7'd77:  b = 8'h41;
      7'd78:  b = 8'h70;
      7'd79:  b = 8'h6f;
      7'd80:  b = 8'h6c;
      7'd81:  b = 8'h6c;
      7'd82:  b = 8'h6f;
      7'd83:  b = 8'h20;
      7'd84:  b = 8'h56;
      7'd85:  b = 8'h44;
      7'd86:  b = 8'h0a;
      7'd87, 7'd88, 7'd89: b = 8'h20;
      7'd93:  b = 8'hfd;
      7'd95:  b = 8'd24;
      7'd96:  b = 8'd240;
      7'd97:  b = 8'd24;
      7'd98:  b = 8'd240;
      7'd99:  b = 8'd240;
      7'd100: b = 8'h01;
      7'd101: b = 8'h0a;
      7'd102, 7'd103, 7'd104, 7'd105, 7'd106, 7'd107: b = 8'h20;
      7'd111: b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/edid_base_block_generator.sv
// ----------------------------------------------------------------------------
// edid_base_block_generator
// 128-byte edid 1.4 base block with one reduced-blanking detailed timing
// ----------------------------------------------------------------------------
// Reads: with busy low, each cycle with start high takes one byte offset; the
// byte comes back on out_edid_byte with out_valid high in the next cycle (the
// blob ram's registered read), one read per cycle sustained while busy stays
// low. Results cannot be stalled and must be taken in the cycle shown. After
// reset and after every write to one of the four registers the block rebuilds
// the blob and holds busy high meanwhile: a 30-step refresh division, two
// multiply stages, a 30-step pixel clock division and a fill of all 128
// ram bytes (the last two skipped for an out-of-range pixel clock, after which
// every read returns zero with out_blob_valid low). cfg_ready is always high.
// ----------------------------------------------------------------------------
module edid_base_block_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ebg_pkg::OFF_W-1:0]       in_byte_offset,
  output logic                            out_valid,
  output logic [7:0]                      out_edid_byte,
  output logic                            out_blob_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ebg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ebg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "edid_base_block_generator_assert.svh"

  ebg_pkg::state_t state_r, state_nxt;

  logic [15:0] frame_width_r;
  logic [15:0] frame_height_r;
  logic [23:0] refresh_num_r;
  logic [15:0] refresh_den_r;

  logic [ebg_pkg::DIM_W-1:0]    w_r, w_nxt;
  logic [ebg_pkg::DIM_W-1:0]    h_r, h_nxt;
  logic [7:0]                   rate_r, rate_nxt;
  logic [ebg_pkg::DIV_W-1:0]    div_num_r, div_num_nxt;
  logic [ebg_pkg::DEN_W-1:0]    div_den_r, div_den_nxt;
  logic [ebg_pkg::DEN_W-1:0]    div_rem_r, div_rem_nxt;
  logic [ebg_pkg::CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [ebg_pkg::PROD_A_W-1:0] prod_a_r, prod_a_nxt;
  logic [ebg_pkg::PROD_B_W-1:0] prod_b_r, prod_b_nxt;
  logic [15:0]                  pclk_r, pclk_nxt;
  logic [ebg_pkg::OFF_W-1:0]    fill_cnt_r, fill_cnt_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic                         blob_valid_r, blob_valid_nxt;
  logic                         out_valid_r;

  logic                       cfg_hit;
  logic                       rd_en;
  logic                       ram_we;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 ram_rdata;
  logic [7:0]                 fill_byte;
  logic                       in_range;
  logic [ebg_pkg::DEN_W:0]    rem_sh;
  logic [ebg_pkg::DEN_W:0]    rem_sub;
  logic                       q_bit;
  logic                       div_done;
  logic [2*ebg_pkg::DIM_W-1:0] mul_a_full;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     ((cfg_index == ebg_pkg::REG_FRAME_WIDTH)  ||
                      (cfg_index == ebg_pkg::REG_FRAME_HEIGHT) ||
                      (cfg_index == ebg_pkg::REG_REFRESH_NUM)  ||
                      (cfg_index == ebg_pkg::REG_REFRESH_DEN));
  assign rd_en = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ebg_pkg::WIDTH_RESET;
      frame_height_r <= ebg_pkg::HEIGHT_RESET;
      refresh_num_r  <= ebg_pkg::REF_NUM_RESET;
      refresh_den_r  <= ebg_pkg::REF_DEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ebg_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[15:0];
        ebg_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[15:0];
        ebg_pkg::REG_REFRESH_NUM:  refresh_num_r  <= cfg_data;
        ebg_pkg::REG_REFRESH_DEN:  refresh_den_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // shared restoring divider step
  assign rem_sh   = {div_rem_r, div_num_r[ebg_pkg::DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_den_r};
  assign q_bit    = (rem_sh >= {1'b0, div_den_r});
  assign div_done = (div_cnt_r == '0);

  assign mul_a_full = {{ebg_pkg::DIM_W{1'b0}}, w_r + ebg_pkg::H_BLANK} *
                      {{ebg_pkg::DIM_W{1'b0}}, h_r + ebg_pkg::V_BLANK};
  assign in_range   = (prod_b_r >= ebg_pkg::PROD_MIN) && (prod_b_r < ebg_pkg::PROD_LIMIT);
  assign fill_byte  = ebg_pkg::blob_byte(fill_cnt_r, w_r, h_r, pclk_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ebg_pkg::ST_IDLE:     state_nxt = ebg_pkg::ST_IDLE;
      ebg_pkg::ST_SETUP:    state_nxt = ebg_pkg::ST_DIV_RATE;
      ebg_pkg::ST_DIV_RATE: if (div_done) state_nxt = ebg_pkg::ST_RATE;
      ebg_pkg::ST_RATE:     state_nxt = ebg_pkg::ST_MUL_A;
      ebg_pkg::ST_MUL_A:    state_nxt = ebg_pkg::ST_MUL_B;
      ebg_pkg::ST_MUL_B:    state_nxt = ebg_pkg::ST_CHECK;
      ebg_pkg::ST_CHECK:    state_nxt = in_range ? ebg_pkg::ST_DIV_CLK : ebg_pkg::ST_IDLE;
      ebg_pkg::ST_DIV_CLK:  if (div_done) state_nxt = ebg_pkg::ST_FILL;
      ebg_pkg::ST_FILL:     if (fill_cnt_r == '1) state_nxt = ebg_pkg::ST_IDLE;
      default:              state_nxt = ebg_pkg::ST_SETUP;
    endcase
    if (cfg_hit) begin
      state_nxt = ebg_pkg::ST_SETUP;
    end
  end

  // fsm outputs
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_wdata = fill_byte;
    case (state_r)
      ebg_pkg::ST_IDLE: busy = 1'b0;
      ebg_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (fill_cnt_r == '1) begin
          ram_wdata = 8'h00 - sum_r;
        end
      end
      default: ;
    endcase
  end

  // build datapath
  always_comb begin
    w_nxt          = w_r;
    h_nxt          = h_r;
    rate_nxt       = rate_r;
    div_num_nxt    = div_num_r;
    div_den_nxt    = div_den_r;
    div_rem_nxt    = div_rem_r;
    div_cnt_nxt    = div_cnt_r;
    prod_a_nxt     = prod_a_r;
    prod_b_nxt     = prod_b_r;
    pclk_nxt       = pclk_r;
    fill_cnt_nxt   = fill_cnt_r;
    sum_nxt        = sum_r;
    blob_valid_nxt = blob_valid_r;
    case (state_r)
      ebg_pkg::ST_SETUP: begin
        if (frame_width_r < ebg_pkg::WIDTH_MIN) begin
          w_nxt = ebg_pkg::WIDTH_MIN[ebg_pkg::DIM_W-1:0];
        end else if (frame_width_r > ebg_pkg::DIM_MAX) begin
          w_nxt = ebg_pkg::DIM_MAX[ebg_pkg::DIM_W-1:0];
        end else begin
          w_nxt = frame_width_r[ebg_pkg::DIM_W-1:0];
        end
        if (frame_height_r < ebg_pkg::HEIGHT_MIN) begin
          h_nxt = ebg_pkg::HEIGHT_MIN[ebg_pkg::DIM_W-1:0];
        end else if (frame_height_r > ebg_pkg::DIM_MAX) begin
          h_nxt = ebg_pkg::DIM_MAX[ebg_pkg::DIM_W-1:0];
        end else begin
          h_nxt = frame_height_r[ebg_pkg::DIM_W-1:0];
        end
        div_num_nxt = {{(ebg_pkg::DIV_W-24){1'b0}}, refresh_num_r};
        div_den_nxt = (refresh_den_r == '0) ? 16'd1 : refresh_den_r;
        div_rem_nxt = '0;
        div_cnt_nxt = ebg_pkg::CNT_W'(ebg_pkg::DIV_W - 1);
        blob_valid_nxt = 1'b0;
      end
      ebg_pkg::ST_DIV_RATE, ebg_pkg::ST_DIV_CLK: begin
        div_rem_nxt = q_bit ? rem_sub[ebg_pkg::DEN_W-1:0] : rem_sh[ebg_pkg::DEN_W-1:0];
        div_num_nxt = {div_num_r[ebg_pkg::DIV_W-2:0], q_bit};
        if (!div_done) begin
          div_cnt_nxt = div_cnt_r - ebg_pkg::CNT_W'(1);
        end
        if (state_r == ebg_pkg::ST_DIV_CLK && div_done) begin
          pclk_nxt     = div_num_nxt[15:0];
          fill_cnt_nxt = '0;
          sum_nxt      = 8'h00;
        end
      end
      ebg_pkg::ST_RATE: begin
        if (div_num_r == '0) begin
          rate_nxt = ebg_pkg::RATE_DFLT;
        end else if (div_num_r < ebg_pkg::DIV_W'(ebg_pkg::RATE_MIN)) begin
          rate_nxt = ebg_pkg::RATE_MIN;
        end else if (div_num_r > ebg_pkg::DIV_W'(ebg_pkg::RATE_MAX)) begin
          rate_nxt = ebg_pkg::RATE_MAX;
        end else begin
          rate_nxt = div_num_r[7:0];
        end
      end
      ebg_pkg::ST_MUL_A: prod_a_nxt = mul_a_full[ebg_pkg::PROD_A_W-1:0];
      ebg_pkg::ST_MUL_B: prod_b_nxt = ebg_pkg::PROD_B_W'(prod_a_r) * ebg_pkg::PROD_B_W'(rate_r);
      ebg_pkg::ST_CHECK: begin
        div_num_nxt = prod_b_r[ebg_pkg::DIV_W-1:0];
        div_den_nxt = ebg_pkg::CLK_SCALE;
        div_rem_nxt = '0;
        div_cnt_nxt = ebg_pkg::CNT_W'(ebg_pkg::DIV_W - 1);
      end
      ebg_pkg::ST_FILL: begin
        sum_nxt      = sum_r + fill_byte;
        fill_cnt_nxt = fill_cnt_r + ebg_pkg::OFF_W'(1);
        if (fill_cnt_r == '1) begin
          blob_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ebg_pkg::ST_SETUP;
      blob_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
      fill_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      blob_valid_r <= blob_valid_nxt;
      out_valid_r  <= rd_en;
      div_cnt_r    <= div_cnt_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    rate_r    <= rate_nxt;
    div_num_r <= div_num_nxt;
    div_den_r <= div_den_nxt;
    div_rem_r <= div_rem_nxt;
    prod_a_r  <= prod_a_nxt;
    prod_b_r  <= prod_b_nxt;
    pclk_r    <= pclk_nxt;
    sum_r     <= sum_nxt;
  end

  ebg_ram #(
    .WIDTH(8),
    .DEPTH(ebg_pkg::BLOB_BYTES)
  ) u_blob_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_cnt_r),
    .wdata(ram_wdata),
    .raddr(in_byte_offset),
    .rdata(ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_blob_valid = blob_valid_r;
  assign out_edid_byte  = blob_valid_r ? ram_rdata : 8'h00;

  `EBG_ASSERT_NEXT(a_read_one_beat, rd_en, out_valid, "read beat not returned next cycle")
  `EBG_ASSERT_NEXT(a_cfg_rebuilds, cfg_hit, busy, "config write did not rebuild")
  `EBG_ASSERT_NOW(a_empty_reads_zero, out_valid && !out_blob_valid, out_edid_byte == 8'h00,
                  "empty blob returned nonzero beat")
  `EBG_ASSERT_NOW(a_fill_blocks_reads, ram_we, busy, "ram written while reads open")

endmodule

// File: rtl/ebg_ram.sv
// ----------------------------------------------------------------------------
// ebg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ebg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
